FILE: design/nufft_prephase_rotator_assert.svh
// assertion macros for the prephase rotator
// expects clk and rst in the scope of every use
`ifndef NUFFT_PREPHASE_ROTATOR_ASSERT_SVH
`define NUFFT_PREPHASE_ROTATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define NPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define NPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/npr_pkg.sv
// shared types and constants of the prephase rotator
// no dependencies
`timescale 1ns / 1ps

package npr_pkg;

  localparam int LOC_W         = 32;
  localparam int OFS_W         = 32;
  localparam int PROD_W        = 48;   // product bits up to the kept angle field
  localparam int ANG_W         = 32;
  localparam int OUT_FRAC_BITS = 16;
  localparam int OUT_W         = OUT_FRAC_BITS + 2;
  localparam int CORDIC_STEPS  = 30;
  localparam int XY_W          = 34;
  localparam int Z_W           = 33;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMS     = 3'd0,
    CFG_SIGN     = 3'd1,
    CFG_OFFSET_X = 3'd2,
    CFG_OFFSET_Y = 3'd3,
    CFG_OFFSET_Z = 3'd4
  } cfg_reg_e;

  // control that travels beside the datapath of each stage
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [1:0] quad;
  } npr_side_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [Z_W-1:0] atan_turn(input int i);
    logic signed [Z_W-1:0] r;
    begin
      case (i)
        0:  r = Z_W'(536870912);
        1:  r = Z_W'(316933406);
        2:  r = Z_W'(167458907);
        3:  r = Z_W'(85004756);
        4:  r = Z_W'(42667331);
        5:  r = Z_W'(21354465);
        6:  r = Z_W'(10679838);
        7:  r = Z_W'(5340245);
        8:  r = Z_W'(2670163);
        9:  r = Z_W'(1335087);
        10: r = Z_W'(667544);
        11: r = Z_W'(333772);
        12: r = Z_W'(166886);
        13: r = Z_W'(83443);
        14: r = Z_W'(41722);
        15: r = Z_W'(20861);
        16: r = Z_W'(10430);
        17: r = Z_W'(5215);
        18: r = Z_W'(2608);
        19: r = Z_W'(1304);
        20: r = Z_W'(652);
        21: r = Z_W'(326);
        22: r = Z_W'(163);
        23: r = Z_W'(81);
        24: r = Z_W'(41);
        25: r = Z_W'(20);
        26: r = Z_W'(10);
        27: r = Z_W'(5);
        28: r = Z_W'(3);
        29: r = Z_W'(1);
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: design/nufft_prephase_rotator.sv
// top level of the prephase rotator: phase dot product, quadrant fold,
// cordic pipeline and output rounding; depends on npr_pkg, npr_cordic
// and nufft_prephase_rotator_assert.svh
//
//  channel  dir  signals                              contents
//  s        in   s_tvalid s_tready s_tdata s_tlast    one point per transfer
//  m        out  m_tvalid m_tready m_tdata m_tlast    one phasor per transfer
//  cfg      in   cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// one point enters per cycle while the output is not stalled; the stages are: multiply,
// sum, quadrant fold, 30 cordic iterations, quadrant select, round and saturate.
// the whole pipeline advances together whenever the output register is
// empty or being taken, so s_tready follows m_tready and m_tvalid.
// reset clears the stage valid bits and loads the register defaults.
`timescale 1ns / 1ps

module nufft_prephase_rotator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [3*npr_pkg::LOC_W-1:0]           s_tdata,   // loc_x, loc_y, loc_z
  input  logic                                  s_tlast,   // last_point
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [39:0]                           m_tdata,   // real_part, imag_part, zero pad
  output logic                                  m_tlast,   // last_out
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [npr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [npr_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import npr_pkg::*;

  localparam int RND_SH = 30 - OUT_FRAC_BITS;
  localparam logic signed [XY_W-1:0] OUT_LIM = XY_W'(1 << OUT_FRAC_BITS);

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [XY_W-1:0] v,
                                                     input logic neg);
    logic signed [XY_W-1:0] r;
    begin
      r = (v + XY_W'(1 << (RND_SH - 1))) >>> RND_SH;
      if (r > OUT_LIM) r = OUT_LIM;
      if (r < -OUT_LIM) r = -OUT_LIM;
      if (neg) r = -r;
      return r[OUT_W-1:0];
    end
  endfunction

  // configuration registers
  logic [1:0]              dims;
  logic                    sign_neg;
  logic signed [OFS_W-1:0] off_x, off_y, off_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims     <= 2'd1;
      sign_neg <= 1'b0;
      off_x    <= '0;
      off_y    <= '0;
      off_z    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_DIMS:     dims     <= cfg_data[1:0];
        CFG_SIGN:     sign_neg <= cfg_data[0];
        CFG_OFFSET_X: off_x    <= cfg_data;
        CFG_OFFSET_Y: off_y    <= cfg_data;
        CFG_OFFSET_Z: off_z    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic signed [LOC_W-1:0] loc_x, loc_y, loc_z;
  assign loc_x = s_tdata[LOC_W-1:0];
  assign loc_y = s_tdata[2*LOC_W-1:LOC_W];
  assign loc_z = s_tdata[3*LOC_W-1:2*LOC_W];

  // stage 1: products
  logic                     valid1, last1;
  logic [PROD_W-1:0]        px, py, pz;
  logic [PROD_W-1:0]        mx, my, mz;

  assign mx = PROD_W'(loc_x * off_x);
  assign my = PROD_W'(loc_y * off_y);
  assign mz = PROD_W'(loc_z * off_z);

  // stage 2: masked sum, kept angle bits
  logic             valid2, last2;
  logic [ANG_W-1:0] ang;
  logic [PROD_W-1:0] sum_next;
  logic             use_y, use_z;

  assign use_y    = dims[1];
  assign use_z    = (dims == 2'd3);
  assign sum_next = px + (use_y ? py : '0) + (use_z ? pz : '0);

  // stage 3: nearest quadrant and residual
  npr_side_t             side3;
  logic signed [Z_W-1:0] z3;
  logic [ANG_W-1:0]      ang_bias, resid;
  logic [1:0]            quad_next;

  assign ang_bias  = ang + 32'h2000_0000;
  assign quad_next = ang_bias[ANG_W-1:ANG_W-2];
  assign resid     = ang - {quad_next, 30'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1      <= 1'b0;
      valid2      <= 1'b0;
      side3.valid <= 1'b0;
    end else if (adv) begin
      valid1     <= s_tvalid;
      last1      <= s_tlast;
      px         <= mx;
      py         <= my;
      pz         <= mz;
      valid2     <= valid1;
      last2      <= last1;
      ang        <= sum_next[PROD_W-1:16];
      side3.valid <= valid2;
      side3.last  <= last2;
      side3.quad  <= quad_next;
      z3          <= Z_W'($signed(resid));
    end
  end

  npr_side_t              side_c;
  logic signed [XY_W-1:0] xc, yc;

  npr_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_side  (side3),
    .in_z     (z3),
    .out_side (side_c),
    .out_x    (xc),
    .out_y    (yc)
  );

  // quadrant select
  logic                   valid_sel, last_sel;
  logic signed [XY_W-1:0] cos_sel, sin_sel;
  logic signed [OUT_W-1:0] real_q, imag_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_sel <= 1'b0;
      m_tvalid  <= 1'b0;
    end else if (adv) begin
      valid_sel <= side_c.valid;
      last_sel  <= side_c.last;
      case (side_c.quad)
        2'd0: begin cos_sel <= xc;  sin_sel <= yc;  end
        2'd1: begin cos_sel <= -yc; sin_sel <= xc;  end
        2'd2: begin cos_sel <= -xc; sin_sel <= -yc; end
        default: begin cos_sel <= yc; sin_sel <= -xc; end
      endcase
      m_tvalid <= valid_sel;
      m_tlast  <= last_sel;
      real_q   <= to_out(cos_sel, 1'b0);
      imag_q   <= to_out(sin_sel, sign_neg);
    end
  end

  assign m_tdata = {4'd0, imag_q, real_q};

`include "nufft_prephase_rotator_assert.svh"

  `NPR_ASSERT_NOW(a_ready_follows_output, 1'b1, s_tready == (!m_tvalid || m_tready), "s_tready does not follow the output register")
  `NPR_ASSERT_NOW(a_resid_range, side3.valid, z3[Z_W-1:29] == 4'b0000 || z3[Z_W-1:29] == 4'b1111, "cordic residual outside one eighth turn")
  `NPR_ASSERT_NOW(a_real_range, m_tvalid, real_q <= 18'sd65536 && real_q >= -18'sd65536, "real part beyond saturation limit")
  `NPR_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(real_q) && $stable(imag_q), "stalled result changed")

endmodule

FILE: design/npr_cordic.sv
// unrolled rotation-mode cordic, one register stage per iteration
// depends on npr_pkg
`timescale 1ns / 1ps

module npr_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  npr_pkg::npr_side_t                  in_side,
  input  logic signed [npr_pkg::Z_W-1:0]      in_z,
  output npr_pkg::npr_side_t                  out_side,
  output logic signed [npr_pkg::XY_W-1:0]     out_x,
  output logic signed [npr_pkg::XY_W-1:0]     out_y
);
  import npr_pkg::*;

  npr_side_t             side_s [1:CORDIC_STEPS];
  logic signed [XY_W-1:0] x_s   [1:CORDIC_STEPS];
  logic signed [XY_W-1:0] y_s   [1:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_s   [1:CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    npr_side_t              si;
    logic signed [XY_W-1:0] xi, yi;
    logic signed [Z_W-1:0]  zi;

    if (i == 0) begin : g_first
      assign si = in_side;
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = in_z;
    end else begin : g_rest
      assign si = side_s[i];
      assign xi = x_s[i];
      assign yi = y_s[i];
      assign zi = z_s[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side_s[i+1].valid <= 1'b0;
      end else if (adv) begin
        side_s[i+1] <= si;
        // rotate toward zero residual
        if (!zi[Z_W-1]) begin
          x_s[i+1] <= xi - (yi >>> i);
          y_s[i+1] <= yi + (xi >>> i);
          z_s[i+1] <= zi - atan_turn(i);
        end else begin
          x_s[i+1] <= xi + (yi >>> i);
          y_s[i+1] <= yi - (xi >>> i);
          z_s[i+1] <= zi + atan_turn(i);
        end
      end
    end
  end

  assign out_side = side_s[CORDIC_STEPS];
  assign out_x    = x_s[CORDIC_STEPS];
  assign out_y    = y_s[CORDIC_STEPS];

endmodule
